// ===== design/mswd_pkg.sv =====
`timescale 1ns / 1ps

package mswd_pkg;

  // pool geometry
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  // most fire reports a single tick may produce
  localparam int MAX_FIRES  = 8;
  localparam int FCNT_W     = $clog2(MAX_FIRES + 1);

  // field widths
  localparam int CMD_W  = 4;
  localparam int IDX_W  = 3;
  localparam int TIME_W = 32;
  localparam int DL_W   = TIME_W + 1;
  localparam int ACT_W  = 3;
  localparam int ST_W   = 3;
  localparam int CNT_W  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT     = 4'd0,
    CMD_SHUTDOWN = 4'd1,
    CMD_CREATE   = 4'd2,
    CMD_START    = 4'd3,
    CMD_STOP     = 4'd4,
    CMD_KICK     = 4'd5,
    CMD_STATUS   = 4'd6,
    CMD_DESTROY  = 4'd7,
    CMD_TICK     = 4'd8
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_PARAM   = 3'd1,
    ST_NOINIT  = 3'd2,
    ST_EXHAUST = 3'd3,
    ST_NOKICK  = 3'd4
  } status_e;

  localparam logic [ACT_W-1:0] ACT_LOG      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FAILOVER = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CUSTOM   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_MAX      = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              exec;
    logic              scan;
    logic              finish;
    logic [SLOT_W-1:0] scan_idx;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic manager_on;
  } dp_stat_t;

  typedef struct packed {
    status_e           status_code;
    logic [IDX_W-1:0]  result_slot;
    logic              is_active;
    logic [CNT_W-1:0]  kick_count;
    logic [CNT_W-1:0]  fire_count;
    logic [CNT_W-1:0]  recovery_count;
    logic [TIME_W-1:0] since_kick_ms;
    logic [DL_W-1:0]   until_fire_ms;
    logic              fire_event;
    logic [ACT_W-1:0]  fire_action;
    logic              last_result;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0] timeout;
    logic [ACT_W-1:0]  action;
    logic [DL_W-1:0]   deadline;
    logic [TIME_W-1:0] last_kick;
    logic [CNT_W-1:0]  kicks;
    logic [CNT_W-1:0]  fires;
    logic [CNT_W-1:0]  recoveries;
  } entry_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    return SLOT_W'(idx);
  endfunction

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return 32'(idx) < SLOT_COUNT;
  endfunction

endpackage

// ===== design/mswd_ctrl.sv =====
`timescale 1ns / 1ps

module mswd_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic [mswd_pkg::CMD_W-1:0]   command_i,
  input  mswd_pkg::dp_stat_t           stat_i,
  output mswd_pkg::ctrl_cmd_t          cmd_o,
  output logic                         busy
);
  import mswd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] scan_q, scan_d;

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          scan_d = '0;
          if (cmd_e'(command_i) == CMD_TICK && stat_i.manager_on) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: state_d = S_IDLE;
      S_SCAN: begin
        if (scan_q == SLOT_W'(SLOT_COUNT - 1)) begin
          state_d = S_FIN;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign cmd_o.load      = (state_q == S_IDLE) && start;
  assign cmd_o.exec      = (state_q == S_EXEC);
  assign cmd_o.scan      = (state_q == S_SCAN);
  assign cmd_o.finish    = (state_q == S_FIN);
  assign cmd_o.scan_idx  = scan_q;

endmodule

// ===== design/mswd_dp.sv =====
`timescale 1ns / 1ps

module mswd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mswd_pkg::ctrl_cmd_t           cmd_i,
  input  logic [mswd_pkg::CMD_W-1:0]    command_i,
  input  logic [mswd_pkg::IDX_W-1:0]    slot_index_i,
  input  logic [mswd_pkg::TIME_W-1:0]   now_ms_i,
  input  logic [mswd_pkg::TIME_W-1:0]   period_ms_i,
  input  logic [mswd_pkg::ACT_W-1:0]    action_code_i,
  input  logic                          has_handler_i,
  output mswd_pkg::dp_stat_t            stat_o,
  output mswd_pkg::result_t             res_o,
  output logic                          strobe_o
);
  import mswd_pkg::*;

  // item held for the duration of the command
  logic [CMD_W-1:0]  command_q;
  logic [IDX_W-1:0]  idx_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] tmo_q;
  logic [ACT_W-1:0]  act_q;
  logic              handler_q;

  // slot state
  logic                  mgr_q, mgr_d;
  logic [SLOT_COUNT-1:0] used_q, used_d;
  logic [SLOT_COUNT-1:0] run_q, run_d;
  logic [SLOT_COUNT-1:0] fired_q, fired_d;
  entry_t                ent_q [SLOT_COUNT];

  // pending fire report, held back until we know whether it is the last
  logic              pend_v_q, pend_v_d;
  logic [IDX_W-1:0]  pend_slot_q, pend_slot_d;
  logic [ACT_W-1:0]  pend_act_q, pend_act_d;
  logic [FCNT_W-1:0] fcnt_q, fcnt_d;

  result_t res_q, res_d;
  logic    strobe_q, emit;

  logic [SLOT_W-1:0] rd_addr, wr_addr, free_slot;
  logic              free_found, valid, bad_param, due;
  logic              wr_en;
  entry_t            rd, wr_ent;
  logic [DL_W-1:0]   now33, new_dl;

  always_comb begin
    rd_addr = cmd_i.scan ? cmd_i.scan_idx : slot_of(idx_q);
    rd      = ent_q[rd_addr];
    now33   = {1'b0, now_q};
    new_dl  = now33 + {1'b0, rd.timeout};
    valid   = idx_ok(idx_q) && used_q[rd_addr];

    free_found = 1'b0;
    free_slot  = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!free_found && !used_q[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end

    bad_param = (tmo_q == '0) || (act_q > ACT_MAX) ||
                (((act_q == ACT_FAILOVER) || (act_q == ACT_CUSTOM)) && !handler_q);

    due = used_q[rd_addr] && run_q[rd_addr] && !fired_q[rd_addr] &&
          (now33 >= rd.deadline) && (32'(fcnt_q) < MAX_FIRES);

    mgr_d       = mgr_q;
    used_d      = used_q;
    run_d       = run_q;
    fired_d     = fired_q;
    pend_v_d    = pend_v_q;
    pend_slot_d = pend_slot_q;
    pend_act_d  = pend_act_q;
    fcnt_d      = fcnt_q;
    wr_en       = 1'b0;
    wr_addr     = rd_addr;
    wr_ent      = rd;
    emit        = 1'b0;
    res_d       = '0;
    res_d.status_code = ST_OK;
    res_d.last_result = 1'b1;

    if (cmd_i.load) begin
      pend_v_d = 1'b0;
      fcnt_d   = '0;
    end

    if (cmd_i.exec) begin
      emit = 1'b1;
      case (cmd_e'(command_q))
        CMD_INIT: begin
          if (!mgr_q) begin
            used_d  = '0;
            run_d   = '0;
            fired_d = '0;
            mgr_d   = 1'b1;
          end
        end
        CMD_SHUTDOWN: begin
          run_d = '0;
          mgr_d = 1'b0;
        end
        CMD_CREATE: begin
          if (bad_param) begin
            res_d.status_code = ST_PARAM;
          end else if (!mgr_q) begin
            res_d.status_code = ST_NOINIT;
          end else if (!free_found) begin
            res_d.status_code = ST_EXHAUST;
          end else begin
            wr_en              = 1'b1;
            wr_addr            = free_slot;
            wr_ent             = '0;
            wr_ent.timeout     = tmo_q;
            wr_ent.action      = act_q;
            used_d[free_slot]  = 1'b1;
            run_d[free_slot]   = 1'b0;
            fired_d[free_slot] = 1'b0;
            res_d.result_slot  = IDX_W'(free_slot);
          end
        end
        CMD_START: begin
          if (!valid) begin
            res_d.status_code = ST_PARAM;
          end else begin
            run_d[rd_addr]   = 1'b1;
            fired_d[rd_addr] = 1'b0;
            wr_en            = 1'b1;
            wr_ent.deadline  = new_dl;
            wr_ent.last_kick = now_q;
          end
        end
        CMD_STOP: begin
          if (!valid) begin
            res_d.status_code = ST_PARAM;
          end else begin
            run_d[rd_addr] = 1'b0;
          end
        end
        CMD_KICK: begin
          if (!valid) begin
            res_d.status_code = ST_PARAM;
          end else if (!run_q[rd_addr] || fired_q[rd_addr]) begin
            res_d.status_code = ST_NOKICK;
          end else begin
            wr_en            = 1'b1;
            wr_ent.deadline  = new_dl;
            wr_ent.last_kick = now_q;
            wr_ent.kicks     = rd.kicks + 1'b1;
          end
        end
        CMD_STATUS: begin
          if (!valid) begin
            res_d.status_code = ST_PARAM;
          end else begin
            res_d.is_active      = run_q[rd_addr];
            res_d.kick_count     = rd.kicks;
            res_d.fire_count     = rd.fires;
            res_d.recovery_count = rd.recoveries;
            res_d.since_kick_ms  = (now_q >= rd.last_kick) ? (now_q - rd.last_kick) : '0;
            res_d.until_fire_ms  = (rd.deadline > now33) ? (rd.deadline - now33) : '0;
          end
        end
        CMD_DESTROY: begin
          if (!valid) begin
            res_d.status_code = ST_PARAM;
          end else begin
            run_d[rd_addr]  = 1'b0;
            used_d[rd_addr] = 1'b0;
          end
        end
        // only reaches here with the manager off
        CMD_TICK: res_d.status_code = ST_NOINIT;
        default:  res_d.status_code = ST_PARAM;
      endcase
    end

    if (cmd_i.scan && due) begin
      fired_d[rd_addr]  = 1'b1;
      wr_en             = 1'b1;
      wr_ent.fires      = rd.fires + 1'b1;
      if (rd.action != ACT_LOG) begin
        wr_ent.recoveries = rd.recoveries + 1'b1;
      end
      fcnt_d = fcnt_q + 1'b1;
      // flush the previous report, it is not the last one
      if (pend_v_q) begin
        emit              = 1'b1;
        res_d.result_slot = pend_slot_q;
        res_d.fire_event  = 1'b1;
        res_d.fire_action = pend_act_q;
        res_d.last_result = 1'b0;
      end
      pend_v_d    = 1'b1;
      pend_slot_d = IDX_W'(rd_addr);
      pend_act_d  = rd.action;
    end

    if (cmd_i.finish) begin
      emit = 1'b1;
      if (pend_v_q) begin
        res_d.result_slot = pend_slot_q;
        res_d.fire_event  = 1'b1;
        res_d.fire_action = pend_act_q;
      end
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      command_q <= command_i;
      idx_q     <= slot_index_i;
      now_q     <= now_ms_i;
      tmo_q     <= period_ms_i;
      act_q     <= action_code_i;
      handler_q <= has_handler_i;
    end
    if (wr_en) begin
      ent_q[wr_addr] <= wr_ent;
    end
    if (emit) begin
      res_q <= res_d;
    end
    pend_slot_q <= pend_slot_d;
    pend_act_q  <= pend_act_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mgr_q    <= 1'b0;
      used_q   <= '0;
      run_q    <= '0;
      fired_q  <= '0;
      pend_v_q <= 1'b0;
      fcnt_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      mgr_q    <= mgr_d;
      used_q   <= used_d;
      run_q    <= run_d;
      fired_q  <= fired_d;
      pend_v_q <= pend_v_d;
      fcnt_q   <= fcnt_d;
      strobe_q <= emit;
    end
  end

  assign stat_o.manager_on = mgr_q;
  assign res_o             = res_q;
  assign strobe_o          = strobe_q;

endmodule

// ===== design/multi_slot_watchdog_pool_unit.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// command   in         start high, busy low   command, slot_index, now_ms, period_ms,
//                                             action_code, has_handler
// result    out        strobe_o, one cycle    status_code .. last_result
//
// a non-tick item keeps busy high while it executes; its single result
// is on the ports in the next cycle, the first one in which another item can be taken
// a tick with the manager on keeps busy high for the scan and a closing step: the scan
// reads one slot per cycle through the single entry read port, then the closing step follows;
// a fire report is held back until another slot fires or the scan closes, so the
// last one can be marked; the final result shows in the first cycle with busy low
// reset clears the manager flag and all slot flags at once; no clearing pass
// results cannot be held off; each is strobed for one cycle and stays only until the next replaces it

module multi_slot_watchdog_pool_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [mswd_pkg::CMD_W-1:0]    command_i,
  input  logic [mswd_pkg::IDX_W-1:0]    slot_index_i,
  input  logic [mswd_pkg::TIME_W-1:0]   now_ms_i,
  input  logic [mswd_pkg::TIME_W-1:0]   period_ms_i,
  input  logic [mswd_pkg::ACT_W-1:0]    action_code_i,
  input  logic                          has_handler_i,
  // result channel
  output logic                          strobe_o,
  output logic [mswd_pkg::ST_W-1:0]     status_code_o,
  output logic [mswd_pkg::IDX_W-1:0]    result_slot_o,
  output logic                          is_active_o,
  output logic [mswd_pkg::CNT_W-1:0]    kick_count_o,
  output logic [mswd_pkg::CNT_W-1:0]    fire_count_o,
  output logic [mswd_pkg::CNT_W-1:0]    recovery_count_o,
  output logic [mswd_pkg::TIME_W-1:0]   since_kick_ms_o,
  output logic [mswd_pkg::DL_W-1:0]     until_fire_ms_o,
  output logic                          fire_event_o,
  output logic [mswd_pkg::ACT_W-1:0]    fire_action_o,
  output logic                          last_result_o
);
  import mswd_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;
  result_t   res;

  // sequencer: accept, single-step execute, or slot-by-slot tick scan
  mswd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (dp_stat),
    .cmd_o     (ctrl_cmd),
    .busy      (busy)
  );

  // slot table, command decode and result register
  mswd_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .command_i     (command_i),
    .slot_index_i  (slot_index_i),
    .now_ms_i      (now_ms_i),
    .period_ms_i   (period_ms_i),
    .action_code_i (action_code_i),
    .has_handler_i (has_handler_i),
    .stat_o        (dp_stat),
    .res_o         (res),
    .strobe_o      (strobe_o)
  );

  assign status_code_o    = res.status_code;
  assign result_slot_o    = res.result_slot;
  assign is_active_o      = res.is_active;
  assign kick_count_o     = res.kick_count;
  assign fire_count_o     = res.fire_count;
  assign recovery_count_o = res.recovery_count;
  assign since_kick_ms_o  = res.since_kick_ms;
  assign until_fire_ms_o  = res.until_fire_ms;
  assign fire_event_o     = res.fire_event;
  assign fire_action_o    = res.fire_action;
  assign last_result_o    = res.last_result;

endmodule

// ===== verif/multi_slot_watchdog_pool_unit_test.sv =====
`timescale 1ns / 1ps

module multi_slot_watchdog_pool_unit_test;
  import mswd_pkg::*;

  // action codes that the package leaves unnamed
  localparam logic [ACT_W-1:0] ACT_SAFESTATE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REBOOT    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CODE_TOP  = '1;
  // highest value the command field can carry, past the last real command
  localparam logic [CMD_W-1:0] CMD_CODE_TOP  = '1;

  localparam int STALL_LIMIT   = 1000;  // cycles with no item and no result
  localparam int SETTLE_CYCLES = 20;    // outlasts a full tick scan plus the result register

  // dut ports
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    command_i;
  logic [IDX_W-1:0]    slot_index_i;
  logic [TIME_W-1:0]   now_ms_i;
  logic [TIME_W-1:0]   period_ms_i;
  logic [ACT_W-1:0]    action_code_i;
  logic                has_handler_i;
  logic                strobe_o;
  logic [ST_W-1:0]     status_code_o;
  logic [IDX_W-1:0]    result_slot_o;
  logic                is_active_o;
  logic [CNT_W-1:0]    kick_count_o;
  logic [CNT_W-1:0]    fire_count_o;
  logic [CNT_W-1:0]    recovery_count_o;
  logic [TIME_W-1:0]   since_kick_ms_o;
  logic [DL_W-1:0]     until_fire_ms_o;
  logic                fire_event_o;
  logic [ACT_W-1:0]    fire_action_o;
  logic                last_result_o;

  // shadow copy of the watchdog pool
  bit                  pool_on;
  bit                  slot_taken    [SLOT_COUNT];
  bit                  slot_counting [SLOT_COUNT];
  bit                  slot_tripped  [SLOT_COUNT];
  bit [TIME_W-1:0]     slot_period   [SLOT_COUNT];
  bit [ACT_W-1:0]      slot_recovery [SLOT_COUNT];
  bit [DL_W-1:0]       slot_due      [SLOT_COUNT];
  bit [TIME_W-1:0]     slot_kicked_at[SLOT_COUNT];
  bit [CNT_W-1:0]      slot_kick_tally [SLOT_COUNT];
  bit [CNT_W-1:0]      slot_fire_tally [SLOT_COUNT];
  bit [CNT_W-1:0]      slot_rescue_tally[SLOT_COUNT];

  // results still owed by the block, oldest first
  result_t             owed_results[$];
  result_t             oldest_owed;
  int                  error_count;
  bit                  gaps_on;
  bit [TIME_W-1:0]     wall_ms;

  multi_slot_watchdog_pool_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .slot_index_i     (slot_index_i),
    .now_ms_i         (now_ms_i),
    .period_ms_i      (period_ms_i),
    .action_code_i    (action_code_i),
    .has_handler_i    (has_handler_i),
    .strobe_o         (strobe_o),
    .status_code_o    (status_code_o),
    .result_slot_o    (result_slot_o),
    .is_active_o      (is_active_o),
    .kick_count_o     (kick_count_o),
    .fire_count_o     (fire_count_o),
    .recovery_count_o (recovery_count_o),
    .since_kick_ms_o  (since_kick_ms_o),
    .until_fire_ms_o  (until_fire_ms_o),
    .fire_event_o     (fire_event_o),
    .fire_action_o    (fire_action_o),
    .last_result_o    (last_result_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic wipe_slot(input int i);
    slot_taken[i]        = 1'b0;
    slot_counting[i]     = 1'b0;
    slot_tripped[i]      = 1'b0;
    slot_period[i]       = '0;
    slot_recovery[i]     = ACT_LOG;
    slot_due[i]          = '0;
    slot_kicked_at[i]    = '0;
    slot_kick_tally[i]   = '0;
    slot_fire_tally[i]   = '0;
    slot_rescue_tally[i] = '0;
  endtask

  // applies one command to the shadow pool and queues the results it owes
  task automatic advance_pool(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                              input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] tmo,
                              input logic [ACT_W-1:0] act, input logic hnd);
    result_t   res;
    result_t   fired[$];
    bit        slot_ok;
    bit        placed;
    int        s;
    res             = '0;
    res.status_code = ST_OK;
    res.last_result = 1'b1;
    s               = int'(idx);
    slot_ok         = (s < SLOT_COUNT) && slot_taken[s];
    placed          = 1'b0;
    case (cmd)
      CMD_INIT: begin
        if (!pool_on) begin
          for (int i = 0; i < SLOT_COUNT; i++) wipe_slot(i);
          pool_on = 1'b1;
        end
      end
      CMD_SHUTDOWN: begin
        for (int i = 0; i < SLOT_COUNT; i++) slot_counting[i] = 1'b0;
        pool_on = 1'b0;
      end
      CMD_CREATE: begin
        // parameter check comes before the manager check
        if (tmo == '0 || act > ACT_MAX ||
            ((act == ACT_FAILOVER || act == ACT_CUSTOM) && !hnd)) begin
          res.status_code = ST_PARAM;
        end else if (!pool_on) begin
          res.status_code = ST_NOINIT;
        end else begin
          res.status_code = ST_EXHAUST;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!placed && !slot_taken[i]) begin
              wipe_slot(i);
              slot_taken[i]    = 1'b1;
              slot_period[i]   = tmo;
              slot_recovery[i] = act;
              res.status_code  = ST_OK;
              res.result_slot  = IDX_W'(i);
              placed           = 1'b1;
            end
          end
        end
      end
      CMD_START: begin
        if (!slot_ok) begin
          res.status_code = ST_PARAM;
        end else begin
          slot_counting[s]  = 1'b1;
          slot_tripped[s]   = 1'b0;
          slot_due[s]       = {1'b0, now} + {1'b0, slot_period[s]};
          slot_kicked_at[s] = now;
        end
      end
      CMD_STOP: begin
        if (!slot_ok) res.status_code = ST_PARAM;
        else slot_counting[s] = 1'b0;
      end
      CMD_KICK: begin
        if (!slot_ok) begin
          res.status_code = ST_PARAM;
        end else if (!slot_counting[s] || slot_tripped[s]) begin
          res.status_code = ST_NOKICK;
        end else begin
          slot_due[s]        = {1'b0, now} + {1'b0, slot_period[s]};
          slot_kicked_at[s]  = now;
          slot_kick_tally[s] = slot_kick_tally[s] + 1'b1;
        end
      end
      CMD_STATUS: begin
        if (!slot_ok) begin
          res.status_code = ST_PARAM;
        end else begin
          res.is_active      = slot_counting[s];
          res.kick_count     = slot_kick_tally[s];
          res.fire_count     = slot_fire_tally[s];
          res.recovery_count = slot_rescue_tally[s];
          res.since_kick_ms  = (now >= slot_kicked_at[s]) ? now - slot_kicked_at[s] : '0;
          res.until_fire_ms  = (slot_due[s] > {1'b0, now}) ? slot_due[s] - {1'b0, now} : '0;
        end
      end
      CMD_DESTROY: begin
        if (!slot_ok) begin
          res.status_code = ST_PARAM;
        end else begin
          slot_counting[s] = 1'b0;
          slot_taken[s]    = 1'b0;
        end
      end
      CMD_TICK: begin
        if (!pool_on) begin
          res.status_code = ST_NOINIT;
        end else begin
          // scan in slot order, one report per slot that trips
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (fired.size() < MAX_FIRES && slot_taken[i] && slot_counting[i] &&
                !slot_tripped[i] && {1'b0, now} >= slot_due[i]) begin
              slot_tripped[i]    = 1'b1;
              slot_fire_tally[i] = slot_fire_tally[i] + 1'b1;
              if (slot_recovery[i] != ACT_LOG)
                slot_rescue_tally[i] = slot_rescue_tally[i] + 1'b1;
              res             = '0;
              res.status_code = ST_OK;
              res.result_slot = IDX_W'(i);
              res.fire_event  = 1'b1;
              res.fire_action = slot_recovery[i];
              fired.push_back(res);
            end
          end
          if (fired.size() != 0) begin
            fired[fired.size() - 1].last_result = 1'b1;
            foreach (fired[k]) owed_results.push_back(fired[k]);
            return;
          end
          res             = '0;
          res.status_code = ST_OK;
          res.last_result = 1'b1;
        end
      end
      default: res.status_code = ST_PARAM;
    endcase
    owed_results.push_back(res);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // presents one item, waits for the block to take it, then maybe idles
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                           input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] tmo,
                           input logic [ACT_W-1:0] act, input logic hnd);
    @(negedge clk_i);
    start         <= 1'b1;
    command_i     <= cmd;
    slot_index_i  <= idx;
    now_ms_i      <= now;
    period_ms_i   <= tmo;
    action_code_i <= act;
    has_handler_i <= hnd;
    do @(posedge clk_i); while (busy);
    advance_pool(cmd, idx, now, tmo, act, hnd);
    if (gaps_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 6));
  endtask

  // lowers start and holds off until every owed result has come back
  task automatic hold_until_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result, status", 64'(status_code_o), '0);
      end else begin
        oldest_owed = owed_results.pop_front();
        if (status_code_o !== oldest_owed.status_code)
          report_mismatch("status_code", 64'(status_code_o), 64'(oldest_owed.status_code));
        if (result_slot_o !== oldest_owed.result_slot)
          report_mismatch("result_slot", 64'(result_slot_o), 64'(oldest_owed.result_slot));
        if (is_active_o !== oldest_owed.is_active)
          report_mismatch("is_active", 64'(is_active_o), 64'(oldest_owed.is_active));
        if (kick_count_o !== oldest_owed.kick_count)
          report_mismatch("kick_count", 64'(kick_count_o), 64'(oldest_owed.kick_count));
        if (fire_count_o !== oldest_owed.fire_count)
          report_mismatch("fire_count", 64'(fire_count_o), 64'(oldest_owed.fire_count));
        if (recovery_count_o !== oldest_owed.recovery_count)
          report_mismatch("recovery_count", 64'(recovery_count_o),
                          64'(oldest_owed.recovery_count));
        if (since_kick_ms_o !== oldest_owed.since_kick_ms)
          report_mismatch("since_kick_ms", 64'(since_kick_ms_o),
                          64'(oldest_owed.since_kick_ms));
        if (until_fire_ms_o !== oldest_owed.until_fire_ms)
          report_mismatch("until_fire_ms", 64'(until_fire_ms_o),
                          64'(oldest_owed.until_fire_ms));
        if (fire_event_o !== oldest_owed.fire_event)
          report_mismatch("fire_event", 64'(fire_event_o), 64'(oldest_owed.fire_event));
        if (fire_action_o !== oldest_owed.fire_action)
          report_mismatch("fire_action", 64'(fire_action_o), 64'(oldest_owed.fire_action));
        if (last_result_o !== oldest_owed.last_result)
          report_mismatch("last_result", 64'(last_result_o), 64'(oldest_owed.last_result));
      end
    end
  end

  // ends the run if neither side moves for too long
  initial begin : stall_guard
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || strobe_o) quiet = 0;
      else quiet++;
    end
    $display("multi_slot_watchdog_pool_unit verification failed");
    $finish;
  end

  // tick, create before init; bad parameters win over the missing manager
  task automatic test_uninitialized_pool();
    send_item(CMD_TICK, '0, '0, '0, ACT_LOG, 1'b0);
    send_item(CMD_CREATE, '0, '0, '0, ACT_CODE_TOP, 1'b0);
    send_item(CMD_CREATE, '0, '0, 32'd5, ACT_SAFESTATE, 1'b0);
  endtask

  // init twice, fill all slots, then overflow and a failover with no handler
  task automatic test_pool_setup();
    logic [TIME_W-1:0] periods [SLOT_COUNT];
    logic [ACT_W-1:0]  actions [SLOT_COUNT];
    periods = '{32'd1, '1, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, '1};
    actions = '{ACT_LOG, ACT_SAFESTATE, ACT_REBOOT, ACT_FAILOVER, ACT_CUSTOM,
                ACT_SAFESTATE, ACT_REBOOT, ACT_LOG};
    send_item(CMD_INIT, '0, '0, '0, ACT_LOG, 1'b0);
    send_item(CMD_INIT, '0, '1, '0, ACT_LOG, 1'b0);
    for (int i = 0; i < SLOT_COUNT; i++)
      send_item(CMD_CREATE, '0, '0, periods[i], actions[i],
                actions[i] == ACT_FAILOVER || actions[i] == ACT_CUSTOM);
    send_item(CMD_CREATE, '0, '0, 32'd9, ACT_REBOOT, 1'b1);
    send_item(CMD_CREATE, '0, '0, 32'd9, ACT_FAILOVER, 1'b0);
  endtask

  // kick of a stopped and of a fired slot, two firings on one tick,
  // a deadline past the 32-bit time range
  task automatic test_kick_and_fire();
    send_item(CMD_KICK, 3'd0, '0, '0, ACT_LOG, 1'b0);
    send_item(CMD_START, 3'd0, '0, '0, ACT_LOG, 1'b0);
    send_item(CMD_START, 3'd2, '0, '0, ACT_LOG, 1'b0);
    send_item(CMD_START, 3'd7, '1, '0, ACT_LOG, 1'b0);
    send_item(CMD_TICK, '0, '1, '0, ACT_LOG, 1'b0);
    send_item(CMD_KICK, 3'd0, '1, '0, ACT_LOG, 1'b0);
    send_item(CMD_STATUS, 3'd7, '0, '0, ACT_LOG, 1'b0);
    send_item(CMD_STATUS, 3'd2, '1, '0, ACT_LOG, 1'b0);
  endtask

  // unknown command, shutdown, destroy of a live and of a freed slot
  task automatic test_teardown();
    send_item(CMD_CODE_TOP, '0, '0, '0, ACT_LOG, 1'b0);
    send_item(CMD_SHUTDOWN, '0, '0, '0, ACT_LOG, 1'b0);
    send_item(CMD_DESTROY, 3'd1, '0, '0, ACT_LOG, 1'b0);
    send_item(CMD_DESTROY, 3'd1, '0, '0, ACT_LOG, 1'b0);
  endtask

  // mostly plausible traffic on a running clock, some raw noise
  task automatic test_random_traffic(input int count, input bit vary_gaps);
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] tmo;
    logic [ACT_W-1:0]  act;
    logic              hnd;
    int                roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      idx  = IDX_W'($urandom_range(0, SLOT_COUNT - 1));
      act  = ACT_W'($urandom_range(ACT_LOG, ACT_MAX));
      hnd  = (act == ACT_FAILOVER || act == ACT_CUSTOM) ? 1'b1 : 1'($urandom_range(0, 1));
      tmo  = $urandom_range(1, 40);
      // time mostly creeps, now and then jumps far enough to trip every slot with a period of 40 ms or less
      wall_ms = wall_ms + (($urandom_range(0, 19) == 0) ? 32'd200 : $urandom_range(0, 12));
      now  = wall_ms;
      if (roll < 15) begin
        cmd = CMD_W'($urandom_range(0, CMD_CODE_TOP));
        now = $urandom;
        tmo = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
        act = ACT_W'($urandom_range(0, ACT_CODE_TOP));
        hnd = 1'($urandom_range(0, 1));
      end else if (!pool_on) begin
        cmd = (roll < 70) ? CMD_INIT : CMD_W'($urandom_range(CMD_INIT, CMD_TICK));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 15)      cmd = CMD_CREATE;
        else if (roll < 35) cmd = CMD_START;
        else if (roll < 55) cmd = CMD_KICK;
        else if (roll < 75) cmd = CMD_TICK;
        else if (roll < 85) cmd = CMD_STATUS;
        else if (roll < 90) cmd = CMD_STOP;
        else if (roll < 95) cmd = CMD_DESTROY;
        else if (roll < 97) cmd = CMD_SHUTDOWN;
        else                cmd = CMD_INIT;
        // a few creates with bad action or missing handler
        if (cmd == CMD_CREATE && $urandom_range(0, 9) == 0) begin
          act = ACT_W'($urandom_range(0, ACT_CODE_TOP));
          hnd = 1'($urandom_range(0, 1));
        end
      end
      send_item(cmd, idx, now, tmo, act, hnd);
      if (vary_gaps && $urandom_range(0, 49) == 0) gaps_on = !gaps_on;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    command_i     = CMD_INIT;
    slot_index_i  = '0;
    now_ms_i      = '0;
    period_ms_i   = '0;
    action_code_i = ACT_LOG;
    has_handler_i = 1'b0;
    error_count   = 0;
    gaps_on       = 1'b1;
    pool_on       = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) wipe_slot(i);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_uninitialized_pool();
    test_pool_setup();
    test_kick_and_fire();
    test_teardown();

    wall_ms = $urandom_range(0, 1000);
    test_random_traffic(200, 1'b1);
    // sender waits for every result before going on
    hold_until_drained();
    // run the clock across the 32-bit wrap
    wall_ms = 32'hFFFF_FF00;
    test_random_traffic(180, 1'b1);
    // back-to-back tail, no gaps
    gaps_on = 1'b0;
    test_random_traffic(60, 1'b0);

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (owed_results.size() != 0)
      report_mismatch("results never delivered", 64'(owed_results.size()), '0);
    if (error_count == 0)
      $display("multi_slot_watchdog_pool_unit verification clean");
    else
      $display("multi_slot_watchdog_pool_unit verification failed");
    $finish;
  end

endmodule
